// ===== hdl/sacache_pkg.sv =====
// Shared types and constants for the set-associative write-back cache.
`default_nettype none
package sacache_pkg;
    localparam int ADDR_BITS_DEF    = 16;
    localparam int MEMORY_BYTES_DEF = 65536;
    localparam int CACHE_KBYTES_DEF = 16;
    localparam int BLOCK_BYTES_DEF  = 32;
    localparam int NUM_WAYS_DEF     = 4;

    localparam int AGE_W    = 8;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 32;

    // floor of log2, for sizes that are not powers of two
    function automatic int flog2(input longint x);
        int n;
        longint v;
        n = 0;
        v = x;
        while (v > 1) begin
            v = v >> 1;
            n = n + 1;
        end
        return n;
    endfunction

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WBACK,
        ST_FILL,
        ST_ACCESS,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic take_req;
        logic lookup_step;
        logic wback_step;
        logic fill_step;
        logic access_step;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic is_hit;
        logic need_wback;
        logic line_done;
    } dp_status_t;
endpackage
`default_nettype wire

// ===== hdl/sacache_ctrl.sv =====
// Controller state machine of the cache: sequences clear, lookup, write-back, fill, access and output.
`default_nettype none
module sacache_ctrl (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    output sacache_pkg::dp_cmd_t     cmd,
    input  sacache_pkg::dp_status_t  status
);
    import sacache_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        mvalid_reg, mvalid_next;

    // state and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        mvalid_next = mvalid_reg;
        if (m_tvalid && m_tready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_req = 1'b1;
                    state_next   = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup_step = 1'b1;
                if (status.scan_done) begin
                    if (status.is_hit) begin
                        state_next = ST_ACCESS;
                    end else if (status.need_wback) begin
                        state_next = ST_WBACK;
                    end else begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_WBACK: begin
                cmd.wback_step = 1'b1;
                if (status.line_done) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (status.line_done) begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                cmd.access_step = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to be free
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = mvalid_reg;

    // a result is only loaded when the output register is empty or draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mvalid_reg || m_tready))
        else $error("result loaded over a waiting one");
    // no request is taken while the line state is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request taken during clear");
    // every loaded result leaves m_tvalid high next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result lost");
endmodule
`default_nettype wire

// ===== hdl/sacache_dp.sv =====
// Datapath of the cache: set state, line data, backing memory and counters.
`default_nettype none
module sacache_dp #(
    parameter int ADDR_BITS    = sacache_pkg::ADDR_BITS_DEF,
    parameter int MEMORY_BYTES = sacache_pkg::MEMORY_BYTES_DEF,
    parameter int CACHE_KBYTES = sacache_pkg::CACHE_KBYTES_DEF,
    parameter int BLOCK_BYTES  = sacache_pkg::BLOCK_BYTES_DEF,
    parameter int NUM_WAYS     = sacache_pkg::NUM_WAYS_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  sacache_pkg::dp_cmd_t       cmd,
    output sacache_pkg::dp_status_t    status,
    input  wire                        req_type,
    input  wire  [15:0]                address,
    input  wire  [7:0]                 write_data,
    output logic [7:0]                 read_data,
    output logic                       hit,
    output logic                       wrote_back,
    output logic [31:0]                hit_total,
    output logic [31:0]                miss_total
);
    import sacache_pkg::*;

    localparam int MEM_AW    = flog2(MEMORY_BYTES);
    localparam int MEM_SIZE  = 1 << MEM_AW;
    localparam int OFF_W     = flog2(BLOCK_BYTES);
    localparam int LINE_SZ   = 1 << OFF_W;
    localparam int SET_W     = flog2((CACHE_KBYTES * 1024) / (BLOCK_BYTES * NUM_WAYS));
    localparam int NSETS     = 1 << SET_W;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int NLINES    = NSETS * NUM_WAYS;
    localparam int LINE_W    = (NLINES > 1) ? $clog2(NLINES) : 1;
    // address bits kept after masking and memory reduction
    localparam int EFF_AW    = (ADDR_BITS < MEM_AW) ? ADDR_BITS : MEM_AW;
    localparam int TAG_RAW   = EFF_AW - OFF_W - SET_W;
    localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int DATA_AW   = LINE_W + OFF_W;
    localparam int CLR_LEN   = (MEM_SIZE > NSETS) ? MEM_SIZE : NSETS;
    localparam int CLR_W     = $clog2(CLR_LEN) + 1;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
    } line_st_t;

    // all ways of one set, kept in one memory word
    typedef line_st_t [NUM_WAYS-1:0] set_st_t;

    // memories
    set_st_t           set_mem  [NSETS];
    logic [DATA_W-1:0] line_mem [1 << DATA_AW];
    logic [DATA_W-1:0] back_mem [MEM_SIZE];

    // request registers
    logic              wr_reg;
    logic [EFF_AW-1:0] a_reg;
    logic [DATA_W-1:0] wd_reg;
    logic [OFF_W-1:0]  off;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;

    // lookup, transfer and clear registers
    logic              lk_reg;
    set_st_t           st_rd_reg;
    set_st_t           ws_reg;
    logic [WAY_W-1:0]  way_reg;
    logic              hit_reg;
    logic              wb_flag_reg;
    logic [OFF_W:0]    bcnt_reg;
    logic              rd_pend_reg;
    logic [CLR_W-1:0]  clr_reg;
    logic [DATA_W-1:0] ld_rd_reg, bk_rd_reg;
    logic [31:0]       hits_reg, miss_reg;

    // lookup decode
    logic              hit_any, inv_any, need_wb, line_done;
    logic [WAY_W-1:0]  hit_way, inv_way, old_way, vict_way;
    logic [AGE_W-1:0]  old_age;
    set_st_t           set_upd;

    logic [LINE_W-1:0]  cur_line;
    logic [TAG_W-1:0]   vict_tag;
    logic [OFF_W-1:0]   boff;
    logic [DATA_AW-1:0] ld_addr;
    logic [MEM_AW-1:0]  bk_addr, wb_base, fl_base;

    assign off     = a_reg[OFF_W-1:0];
    assign set_idx = a_reg[OFF_W +: SET_W];
    generate
        if (TAG_RAW > 0) begin : g_tag
            assign tag = a_reg[EFF_AW-1 -: TAG_W];
        end else begin : g_notag
            assign tag = '0;
        end
    endgenerate

    // line index of a way in the current set
    function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
                                                 input logic [WAY_W-1:0] w);
        logic [LINE_W+WAY_W:0] t;
        t = (LINE_W+WAY_W+1)'(s) * (LINE_W+WAY_W+1)'(NUM_WAYS) + (LINE_W+WAY_W+1)'(w);
        return t[LINE_W-1:0];
    endfunction

    assign cur_line = line_of(set_idx, way_reg);
    // write-back address rebuilt from the victim tag
    assign vict_tag = ws_reg[way_reg].tag;
    assign wb_base  = MEM_AW'(EFF_AW'({vict_tag, set_idx, {OFF_W{1'b0}}}));
    assign fl_base  = MEM_AW'({a_reg[EFF_AW-1:OFF_W], {OFF_W{1'b0}}});

    assign boff      = bcnt_reg[OFF_W-1:0];
    assign ld_addr   = {cur_line, (cmd.wback_step ? boff : off)};
    assign bk_addr   = fl_base + MEM_AW'(bcnt_reg);
    assign line_done = (bcnt_reg == (OFF_W+1)'(LINE_SZ));

    // clear pass over set states and backing memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_step && clr_reg != CLR_W'(CLR_LEN)) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // set state memory: registered read of the request's set
    always_ff @(posedge aclk) begin
        st_rd_reg <= set_mem[set_idx];
        if (cmd.clear_step && clr_reg < CLR_W'(NSETS)) begin
            set_mem[clr_reg[SET_W-1:0]] <= '0;
        end else if (cmd.access_step) begin
            set_mem[set_idx] <= set_upd;
        end
    end

    // backing memory
    always_ff @(posedge aclk) begin
        bk_rd_reg <= back_mem[bk_addr];
        if (cmd.clear_step && clr_reg < CLR_W'(MEM_SIZE)) begin
            back_mem[clr_reg[MEM_AW-1:0]] <= '0;
        end else if (cmd.wback_step && rd_pend_reg) begin
            back_mem[wb_base + MEM_AW'(bcnt_reg - 1'b1)] <= ld_rd_reg;
        end
    end

    // line data memory
    always_ff @(posedge aclk) begin
        ld_rd_reg <= line_mem[ld_addr];
        if (cmd.fill_step && rd_pend_reg) begin
            line_mem[{cur_line, OFF_W'(bcnt_reg - 1'b1)}] <= bk_rd_reg;
        end else if (cmd.access_step && wr_reg) begin
            line_mem[ld_addr] <= wd_reg;
        end
    end

    // hit way, first invalid way and oldest way (ties to the lowest)
    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        old_way = '0;
        old_age = st_rd_reg[0].age;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!hit_any && st_rd_reg[w].valid && st_rd_reg[w].tag == tag) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!inv_any && !st_rd_reg[w].valid) begin
                inv_any = 1'b1;
                inv_way = WAY_W'(w);
            end
            if (st_rd_reg[w].age > old_age) begin
                old_age = st_rd_reg[w].age;
                old_way = WAY_W'(w);
            end
        end
        vict_way = inv_any ? inv_way : old_way;
        need_wb  = !hit_any && !inv_any && st_rd_reg[old_way].dirty;
    end

    // set state after the access: ages saturate, used way goes to zero
    always_comb begin
        set_upd = ws_reg;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (ws_reg[w].age != '1) begin
                set_upd[w].age = ws_reg[w].age + 1'b1;
            end
        end
        set_upd[way_reg].tag   = tag;
        set_upd[way_reg].valid = 1'b1;
        set_upd[way_reg].dirty = wr_reg | (hit_reg & ws_reg[way_reg].dirty);
        set_upd[way_reg].age   = '0;
    end

    // request capture, lookup decision and byte counter
    always_ff @(posedge aclk) begin
        if (cmd.take_req) begin
            wr_reg      <= req_type;
            a_reg       <= EFF_AW'(address);
            wd_reg      <= write_data;
            lk_reg      <= 1'b0;
            bcnt_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end else if (cmd.lookup_step) begin
            lk_reg <= 1'b1;
            if (lk_reg) begin
                ws_reg      <= st_rd_reg;
                way_reg     <= hit_any ? hit_way : vict_way;
                hit_reg     <= hit_any;
                wb_flag_reg <= need_wb;
            end
        end else if (cmd.wback_step || cmd.fill_step) begin
            if (line_done) begin
                bcnt_reg    <= '0;
                rd_pend_reg <= 1'b0;
            end else begin
                bcnt_reg    <= bcnt_reg + 1'b1;
                rd_pend_reg <= 1'b1;
            end
        end
    end

    // status to the controller; the set read is valid once lk_reg is set in lookup
    always_comb begin
        status.clear_done = (clr_reg == CLR_W'(CLR_LEN));
        status.scan_done  = lk_reg;
        status.is_hit     = hit_any;
        status.need_wback = need_wb;
        status.line_done  = line_done;
    end

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_reg <= '0;
            miss_reg <= '0;
        end else if (cmd.access_step) begin
            if (hit_reg) hits_reg <= hits_reg + 1'b1;
            else         miss_reg <= miss_reg + 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            read_data  <= wr_reg ? '0 : ld_rd_reg;
            hit        <= hit_reg;
            wrote_back <= wb_flag_reg;
            hit_total  <= hits_reg;
            miss_total <= miss_reg;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/set_assoc_writeback_cache_unit.sv =====
// Top level of the set-associative write-back cache.
//
// Requests arrive on the s_ channel: tdata = {write_data, address, req_type}
// from bit 0 up. One result per request leaves on the m_ channel.
// After reset a clearing pass walks the set state and the backing memory,
// one entry a cycle, over the larger of the backing memory size (MEMORY_BYTES
// rounded down to a power of two) and the set count, while s_tready stays low.
// A request is accepted only when the controller is idle; one is in flight
// at a time. A hit passes through lookup (registered set read), access and
// output load; the next request can be accepted once the result is loaded.
// A miss adds a fill of the line, and a dirty victim a write-back of the
// line before it, one byte a cycle. The result waits in the output register
// while m_tready is low; the next request can be accepted then, and its
// result is held until the register frees, with s_tready low meanwhile.
`default_nettype none
module set_assoc_writeback_cache_unit #(
    parameter int ADDR_BITS    = sacache_pkg::ADDR_BITS_DEF,
    parameter int MEMORY_BYTES = sacache_pkg::MEMORY_BYTES_DEF,
    parameter int CACHE_KBYTES = sacache_pkg::CACHE_KBYTES_DEF,
    parameter int BLOCK_BYTES  = sacache_pkg::BLOCK_BYTES_DEF,
    parameter int NUM_WAYS     = sacache_pkg::NUM_WAYS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // req_type[0], address[16:1], write_data[24:17]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata    // read_data[7:0], hit[8], wrote_back[9],
                                   // hit_total[41:10], miss_total[73:42]
);
    import sacache_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [7:0]  rdata;
    logic        hit_o, wb_o;
    logic [31:0] htot, mtot;

    sacache_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cmd(cmd), .status(status)
    );

    sacache_dp #(
        .ADDR_BITS(ADDR_BITS), .MEMORY_BYTES(MEMORY_BYTES),
        .CACHE_KBYTES(CACHE_KBYTES), .BLOCK_BYTES(BLOCK_BYTES),
        .NUM_WAYS(NUM_WAYS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .req_type(s_tdata[0]), .address(s_tdata[16:1]), .write_data(s_tdata[24:17]),
        .read_data(rdata), .hit(hit_o), .wrote_back(wb_o),
        .hit_total(htot), .miss_total(mtot)
    );

    assign m_tdata = {6'b0, mtot, htot, wb_o, hit_o, rdata};
endmodule
`default_nettype wire
